// ===== hdl/fpc_pkg.sv =====
// Package: shared types, constants and header tables for the framed prefix calculator.
package fpc_pkg;

	localparam int MAX_EXPR_BYTES_DEF = 4096;
	localparam int STACK_DEPTH_DEF    = 64;
	localparam int JOBQ_DEPTH         = 4;
	localparam int CFG_IDX_W          = 8;
	localparam int DISCARD_BYTES      = 17;
	localparam int LEN_BYTES          = 4;

	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_M     = 8'h6d;
	localparam logic [7:0] CH_ADD   = 8'h2b;
	localparam logic [7:0] CH_SUB   = 8'h2d;
	localparam logic [7:0] CH_MUL   = 8'h2a;
	localparam logic [7:0] CH_DIV   = 8'h2f;

	localparam logic [7:0] INIT_LIFE_RST    = 8'd10;
	localparam logic [7:0] REFRESH_LIFE_RST = 8'd5;

	localparam logic [CFG_IDX_W-1:0] REG_INIT_LIFE    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REFRESH_LIFE = 8'd1;

	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_HB    = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;

	typedef enum logic [1:0] {
		JOB_HB    = 2'd0,
		JOB_CLOSE = 2'd1,
		JOB_EVAL  = 2'd2
	} job_kind_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic [1:0] out_kind;
		logic       out_fault;
	} result_t;

	// Frame header byte for heartbeat (is_hb) or reply, position 0..5
	function automatic logic [7:0] hdr_byte(input logic is_hb, input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = CH_P;
			4'd1:    b = is_hb ? 8'd1 : 8'd4;
			4'd5:    b = is_hb ? CH_H : CH_M;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return (c == CH_ADD) || (c == CH_SUB) || (c == CH_MUL) || (c == CH_DIV);
	endfunction

endpackage

// ===== hdl/fpc_jobq.sv =====
// Job queue between the parser front and the evaluation back.
module fpc_jobq import fpc_pkg::*; #(
	parameter int LEN_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  job_kind_t        push_kind,
	input  logic [LEN_W-1:0] push_len,
	input  logic             pop,
	output job_kind_t        head_kind,
	output logic [LEN_W-1:0] head_len,
	output logic             full,
	output logic             empty
);
	localparam int PTR_W = $clog2(JOBQ_DEPTH);
	localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

	job_kind_t        kind_q [JOBQ_DEPTH];
	logic [LEN_W-1:0] len_q  [JOBQ_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(JOBQ_DEPTH));
	assign empty     = (cnt_q == '0);
	assign head_kind = kind_q[rd_q];
	assign head_len  = len_q[rd_q];

	// Store job kind and length
	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_q] <= push_kind;
			len_q[wr_q]  <= push_len;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= PTR_W'(wr_q + 1'b1);
			if (pop)  rd_q <= PTR_W'(rd_q + 1'b1);
			if (push && !pop)      cnt_q <= CNT_W'(cnt_q + 1'b1);
			else if (pop && !push) cnt_q <= CNT_W'(cnt_q - 1'b1);
		end
	end
endmodule

// ===== hdl/fpc_front.sv =====
// Front end: frame parser, lifetime keeping, configuration and job issue.
module fpc_front import fpc_pkg::*; #(
	parameter int MAX_EXPR_BYTES = MAX_EXPR_BYTES_DEF,
	parameter int LEN_W = $clog2(MAX_EXPR_BYTES + 1),
	parameter int BA_W  = $clog2(MAX_EXPR_BYTES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  in_item_t             item,
	output logic                 busy,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 q_full,
	output logic                 q_push,
	output job_kind_t            q_kind,
	output logic [LEN_W-1:0]     q_len,
	input  logic                 eval_done,
	output logic                 wr_en,
	output logic [BA_W-1:0]      wr_addr,
	output logic [7:0]           wr_data
);
	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_DISCARD = 5'b00010,
		PH_LENGTH  = 5'b00100,
		PH_TYPE    = 5'b01000,
		PH_CONTENT = 5'b10000
	} phase_t;

	phase_t           phase_q;
	logic [7:0]       life_q, refresh_q;
	logic             stopped_q, closed_q, pend_q;
	logic [31:0]      len_q;
	logic [LEN_W-1:0] cnt_q;
	logic             acc;
	logic [31:0]      len_nx;
	logic [LEN_W-1:0] cnt_inc;
	logic [7:0]       b;

	assign busy    = q_full || pend_q;
	assign acc     = start && !busy;
	assign b       = item.data_byte;
	assign len_nx  = {b, len_q[31:8]};
	assign cnt_inc = LEN_W'(cnt_q + 1'b1);

	// Expression bytes go straight to the buffer in the back end
	assign wr_en   = acc && !item.cmd && !closed_q && (phase_q == PH_CONTENT);
	assign wr_addr = cnt_q[BA_W-1:0];
	assign wr_data = b;

	// Decide job issue for this beat
	always_comb begin
		q_push = 1'b0;
		q_kind = JOB_HB;
		q_len  = len_q[LEN_W-1:0];
		if (acc) begin
			if (item.cmd) begin
				q_push = !stopped_q && (life_q != 8'd0);
			end else if (!closed_q) begin
				case (phase_q)
					PH_HEADER: begin
						if (b != CH_G && b != CH_P) begin
							q_push = 1'b1;
							q_kind = JOB_CLOSE;
						end
					end
					PH_LENGTH: begin
						if (cnt_inc >= LEN_W'(LEN_BYTES) &&
							len_nx > 32'(MAX_EXPR_BYTES)) begin
							q_push = 1'b1;
							q_kind = JOB_CLOSE;
						end
					end
					PH_TYPE: begin
						if (b == CH_M) begin
							q_push = (len_q == 32'd0);
							q_kind = JOB_EVAL;
						end else if (b != CH_H) begin
							q_push = 1'b1;
							q_kind = JOB_CLOSE;
						end
					end
					PH_CONTENT: begin
						if (32'(cnt_inc) >= len_q) begin
							q_push = 1'b1;
							q_kind = JOB_EVAL;
						end
					end
					default: q_push = 1'b0;
				endcase
			end
		end
	end

	// Parser and lifetime state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			life_q    <= INIT_LIFE_RST;
			refresh_q <= REFRESH_LIFE_RST;
			stopped_q <= 1'b0;
			closed_q  <= 1'b0;
			pend_q    <= 1'b0;
			len_q     <= '0;
			cnt_q     <= '0;
		end else begin
			if (eval_done) pend_q <= 1'b0;
			if (q_push && q_kind == JOB_EVAL) pend_q <= 1'b1;
			if (q_push && q_kind == JOB_CLOSE) begin
				closed_q <= 1'b1;
				phase_q  <= PH_HEADER;
			end
			if (cfg_valid) begin
				if (cfg_index == REG_INIT_LIFE) life_q <= cfg_data;
				else if (cfg_index == REG_REFRESH_LIFE) refresh_q <= cfg_data;
			end
			if (acc && item.cmd) begin
				if (!stopped_q) begin
					if (life_q == 8'd0 || life_q == 8'd1) stopped_q <= 1'b1;
					if (life_q != 8'd0) life_q <= life_q - 8'd1;
				end
			end else if (acc && !closed_q) begin
				case (phase_q)
					PH_HEADER: begin
						cnt_q <= '0;
						if (b == CH_G) begin
							phase_q <= PH_DISCARD;
						end else if (b == CH_P) begin
							len_q   <= '0;
							phase_q <= PH_LENGTH;
						end
					end
					PH_DISCARD: begin
						cnt_q <= cnt_inc;
						if (cnt_inc >= LEN_W'(DISCARD_BYTES)) phase_q <= PH_HEADER;
					end
					PH_LENGTH: begin
						len_q <= len_nx;
						cnt_q <= cnt_inc;
						if (cnt_inc >= LEN_W'(LEN_BYTES) &&
							len_nx <= 32'(MAX_EXPR_BYTES)) phase_q <= PH_TYPE;
					end
					PH_TYPE: begin
						cnt_q <= '0;
						if (b == CH_H) begin
							life_q  <= refresh_q;
							phase_q <= PH_HEADER;
						end else if (b == CH_M) begin
							phase_q <= (len_q == 32'd0) ? PH_HEADER : PH_CONTENT;
						end
					end
					PH_CONTENT: begin
						cnt_q <= cnt_inc;
						if (32'(cnt_inc) >= len_q) phase_q <= PH_HEADER;
					end
					default: phase_q <= PH_HEADER;
				endcase
			end
		end
	end
endmodule

// ===== hdl/fpc_back.sv =====
// Back end: expression buffer, stack evaluator, divider and result serializer.
module fpc_back import fpc_pkg::*; #(
	parameter int MAX_EXPR_BYTES = MAX_EXPR_BYTES_DEF,
	parameter int STACK_DEPTH    = STACK_DEPTH_DEF,
	parameter int LEN_W = $clog2(MAX_EXPR_BYTES + 1),
	parameter int BA_W  = $clog2(MAX_EXPR_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [BA_W-1:0]  wr_addr,
	input  logic [7:0]       wr_data,
	input  logic             q_empty,
	input  job_kind_t        q_kind,
	input  logic [LEN_W-1:0] q_len,
	output logic             q_pop,
	output logic             eval_done,
	output logic             result_valid,
	output result_t          result
);
	localparam int SA_W = $clog2(STACK_DEPTH);
	localparam int SP_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EMIT   = 7'b0000010,
		S_FETCH  = 7'b0000100,
		S_DECODE = 7'b0001000,
		S_BYTES  = 7'b0010000,
		S_OPER   = 7'b0100000,
		S_DIV    = 7'b1000000
	} state_t;

	logic [7:0]  ebuf [MAX_EXPR_BYTES];
	logic [31:0] stk  [STACK_DEPTH];

	state_t           state_q;
	job_kind_t        kind_q;
	logic [LEN_W-1:0] pos_q;
	logic [SP_W-1:0]  sp_q;
	logic [31:0]      top_q, val_q;
	logic             fault_q, neg_q;
	logic [3:0]       cnt_q;
	logic [1:0]       bcnt_q;
	logic [4:0]       dcnt_q;
	logic [7:0]       op_q;
	logic [31:0]      dvd_q, dvs_q, rem_q;
	logic [7:0]       buf_rd_q;
	logic [31:0]      stk_rd_q;

	logic [LEN_W-1:0] rd_pos;
	logic [SP_W-1:0]  sp_m1, sp_m2;
	logic             stk_we;
	logic [32:0]      rs;
	logic             qbit;
	logic [31:0]      q_full32, l_val, r_val;
	logic             last;
	logic [1:0]       rb_idx;

	assign sp_m1 = SP_W'(sp_q - 1'b1);
	assign sp_m2 = SP_W'(sp_q - 2'd2);
	assign l_val = top_q;
	assign r_val = stk_rd_q;

	// Pick the buffer byte address for the next read
	always_comb begin
		case (state_q)
			S_DECODE: rd_pos = LEN_W'(pos_q - 2'd2);
			S_BYTES:  rd_pos = LEN_W'(pos_q - LEN_W'(3) - LEN_W'(bcnt_q));
			default:  rd_pos = LEN_W'(pos_q - 1'b1);
		endcase
	end

	assign stk_we = (state_q == S_BYTES) && (bcnt_q == 2'd2) && (sp_q != '0);

	// Expression buffer: front writes, evaluator reads
	always_ff @(posedge clk) begin
		if (wr_en) ebuf[wr_addr] <= wr_data;
		buf_rd_q <= ebuf[rd_pos[BA_W-1:0]];
	end

	// Operand stack below the cached top entry
	always_ff @(posedge clk) begin
		if (stk_we) stk[sp_m1[SA_W-1:0]] <= top_q;
		stk_rd_q <= stk[sp_m2[SA_W-1:0]];
	end

	// Divider step: one quotient bit per cycle
	assign rs       = {rem_q, dvd_q[31]};
	assign qbit     = (rs >= {1'b0, dvs_q});
	assign q_full32 = {dvd_q[30:0], qbit};

	assign q_pop     = (state_q == S_IDLE) && !q_empty;

	// Result byte lane for reply beats 6..9
	assign rb_idx = cnt_q[1:0] - 2'd2;

	// Serialize result beats
	always_comb begin
		result_valid     = (state_q == S_EMIT);
		result.out_byte  = 8'd0;
		result.out_last  = 1'b0;
		result.out_kind  = KIND_REPLY;
		result.out_fault = 1'b0;
		case (kind_q)
			JOB_HB: begin
				result.out_byte = hdr_byte(1'b1, cnt_q);
				result.out_last = (cnt_q == 4'd5);
				result.out_kind = KIND_HB;
			end
			JOB_CLOSE: begin
				result.out_last = 1'b1;
				result.out_kind = KIND_CLOSE;
			end
			default: begin
				if (cnt_q < 4'd6)
					result.out_byte = hdr_byte(1'b0, cnt_q);
				else if (!fault_q)
					result.out_byte = top_q[{rb_idx, 3'b000} +: 8];
				result.out_last  = (cnt_q == 4'd9);
				result.out_fault = fault_q;
			end
		endcase
	end

	assign last      = result_valid && result.out_last;
	assign eval_done = last && (kind_q == JOB_EVAL);

	// Evaluation sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= JOB_HB;
			pos_q   <= '0;
			sp_q    <= '0;
			fault_q <= 1'b0;
			cnt_q   <= '0;
			bcnt_q  <= '0;
			dcnt_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						kind_q  <= q_kind;
						cnt_q   <= '0;
						fault_q <= 1'b0;
						pos_q   <= q_len;
						sp_q    <= '0;
						state_q <= (q_kind == JOB_EVAL) ? S_FETCH : S_EMIT;
					end
				end
				S_EMIT: begin
					cnt_q <= cnt_q + 4'd1;
					if (last) state_q <= S_IDLE;
				end
				S_FETCH: begin
					if (pos_q == '0) begin
						fault_q <= (sp_q == '0);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (is_op(buf_rd_q)) begin
						op_q  <= buf_rd_q;
						pos_q <= LEN_W'(pos_q - 1'b1);
						if (sp_q < SP_W'(2)) begin
							fault_q <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_OPER;
						end
					end else if (pos_q < LEN_W'(4) || sp_q == SP_W'(STACK_DEPTH)) begin
						fault_q <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						val_q   <= {24'd0, buf_rd_q};
						bcnt_q  <= '0;
						state_q <= S_BYTES;
					end
				end
				S_BYTES: begin
					val_q  <= {val_q[23:0], buf_rd_q};
					bcnt_q <= bcnt_q + 2'd1;
					if (bcnt_q == 2'd2) begin
						top_q   <= {val_q[23:0], buf_rd_q};
						sp_q    <= SP_W'(sp_q + 1'b1);
						pos_q   <= LEN_W'(pos_q - LEN_W'(4));
						state_q <= S_FETCH;
					end
				end
				S_OPER: begin
					case (op_q)
						CH_ADD: begin
							top_q   <= l_val + r_val;
							sp_q    <= sp_m1;
							state_q <= S_FETCH;
						end
						CH_SUB: begin
							top_q   <= l_val - r_val;
							sp_q    <= sp_m1;
							state_q <= S_FETCH;
						end
						CH_MUL: begin
							top_q   <= 32'(l_val * r_val);
							sp_q    <= sp_m1;
							state_q <= S_FETCH;
						end
						default: begin
							if (r_val == 32'd0) begin
								fault_q <= 1'b1;
								state_q <= S_EMIT;
							end else begin
								dvd_q   <= l_val[31] ? (32'd0 - l_val) : l_val;
								dvs_q   <= r_val[31] ? (32'd0 - r_val) : r_val;
								neg_q   <= l_val[31] ^ r_val[31];
								rem_q   <= '0;
								dcnt_q  <= '0;
								state_q <= S_DIV;
							end
						end
					endcase
				end
				S_DIV: begin
					rem_q  <= qbit ? 32'(rs - {1'b0, dvs_q}) : rs[31:0];
					dvd_q  <= q_full32;
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd31) begin
						top_q   <= neg_q ? (32'd0 - q_full32) : q_full32;
						sp_q    <= sp_m1;
						state_q <= S_FETCH;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/framed_prefix_calc_server_core.sv =====
// Top level: framed prefix calculator with heartbeat, front and back joined by a job queue.
// Output: an item that raises a job is queued; the back pops jobs in order when idle and
// sends their beats one per cycle (6 heartbeat, 1 close, 10 reply), which cannot be stalled.
// Throughput: bytes that raise no job go one per cycle while busy is low; the front stalls
// while four jobs wait, and after an 'm' frame it stalls until the evaluator has sent the
// last beat of its reply.
// Reset: arst_n clears all control state at once; buffer and stack hold no reset value.
module framed_prefix_calc_server_core import fpc_pkg::*; #(
	parameter int MAX_EXPR_BYTES = MAX_EXPR_BYTES_DEF,
	parameter int STACK_DEPTH    = STACK_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  in_item_t             item,
	output logic                 busy,
	output logic                 result_valid,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);
	localparam int LEN_W = $clog2(MAX_EXPR_BYTES + 1);
	localparam int BA_W  = $clog2(MAX_EXPR_BYTES);

	logic             q_full, q_empty, q_push, q_pop, eval_done;
	job_kind_t        push_kind, head_kind;
	logic [LEN_W-1:0] push_len, head_len;
	logic             wr_en;
	logic [BA_W-1:0]  wr_addr;
	logic [7:0]       wr_data;

	assign cfg_ready = 1'b1;

	fpc_front #(.MAX_EXPR_BYTES(MAX_EXPR_BYTES), .LEN_W(LEN_W), .BA_W(BA_W)) u_front (
		.clk, .arst_n, .start, .item, .busy,
		.cfg_valid, .cfg_index, .cfg_data,
		.q_full, .q_push, .q_kind(push_kind), .q_len(push_len),
		.eval_done, .wr_en, .wr_addr, .wr_data
	);

	fpc_jobq #(.LEN_W(LEN_W)) u_jobq (
		.clk, .arst_n,
		.push(q_push), .push_kind, .push_len,
		.pop(q_pop), .head_kind, .head_len,
		.full(q_full), .empty(q_empty)
	);

	fpc_back #(.MAX_EXPR_BYTES(MAX_EXPR_BYTES), .STACK_DEPTH(STACK_DEPTH),
		.LEN_W(LEN_W), .BA_W(BA_W)) u_back (
		.clk, .arst_n, .wr_en, .wr_addr, .wr_data,
		.q_empty, .q_kind(head_kind), .q_len(head_len), .q_pop,
		.eval_done, .result_valid, .result
	);

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full)) else $error("job pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("job popped from empty queue");
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.out_kind == KIND_CLOSE) |-> result.out_last)
		else $error("close beat not marked last");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		eval_done |-> busy) else $error("evaluation finished while front not waiting");
`endif
endmodule
